>>> sv/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types and constants for the resize dimension calculator.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int DIM_BITS_DEF = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int MUL_W        = 32;
  localparam int LIMIT_W      = 16;
  localparam int PCT_W        = 15;
  localparam int PCT_FULL     = 25600;

  typedef enum logic [2:0] {
    MODE_LONG  = 3'd0,
    MODE_SHORT = 3'd1,
    MODE_WIDTH = 3'd2,
    MODE_HEIGHT = 3'd3,
    MODE_PCT   = 3'd4,
    MODE_MEGA  = 3'd5
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 3'd0,
    CFG_LONG   = 3'd1,
    CFG_SHORT  = 3'd2,
    CFG_WIDTH  = 3'd3,
    CFG_HEIGHT = 3'd4,
    CFG_KEEP   = 3'd5,
    CFG_PCT    = 3'd6,
    CFG_PIX    = 3'd7
  } cfg_idx_t;

  // How one output dimension is formed at the end of the pipeline.
  typedef enum logic [1:0] {
    KIND_PASS = 2'd0,
    KIND_DIV  = 2'd1,
    KIND_ROOT = 2'd2
  } kind_t;

endpackage

>>> sv/rdc_front.sv
// ----------------------------------------------------------------------------
// rdc_front
// Mode decode, scaling multiply and dividend set-up, three register stages.
// ----------------------------------------------------------------------------
module rdc_front #(
  parameter int DIM_BITS = rdc_pkg::DIM_BITS_DEF,
  localparam int XW = (DIM_BITS > 16) ? DIM_BITS : 16,
  localparam int PW = DIM_BITS + rdc_pkg::MUL_W,
  localparam int AW = PW + 2,
  localparam int BW = XW + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_vld,
  input  logic [DIM_BITS-1:0]         in_w,
  input  logic [DIM_BITS-1:0]         in_h,
  input  rdc_pkg::mode_t              mode,
  input  logic [rdc_pkg::LIMIT_W-1:0] long_lim,
  input  logic [rdc_pkg::LIMIT_W-1:0] short_lim,
  input  logic [rdc_pkg::LIMIT_W-1:0] width_tgt,
  input  logic [rdc_pkg::LIMIT_W-1:0] height_tgt,
  input  logic                        keep,
  input  logic [rdc_pkg::PCT_W-1:0]   pct,
  input  logic [rdc_pkg::MUL_W-1:0]   pix,
  output logic                        out_vld,
  output logic                        out_inv,
  output logic [1:0][AW-1:0]          out_a,
  output logic [1:0][BW-1:0]          out_b,
  output rdc_pkg::kind_t [1:0]        out_kind,
  output logic [1:0][XW-1:0]          out_pass
);
  import rdc_pkg::*;

  // Stage 1: decode.
  logic                       s1_vld_r, s1_inv_r, s1_mega_r;
  kind_t [1:0]                s1_kind_r;
  logic [1:0][DIM_BITS-1:0]   s1_dim_r;
  logic [1:0][MUL_W-1:0]      s1_mul_r;
  logic [1:0][XW-1:0]         s1_den_r, s1_pass_r;

  kind_t [1:0]                kind_nxt;
  logic [1:0][MUL_W-1:0]      mul_nxt;
  logic [1:0][XW-1:0]         den_nxt, pass_nxt;
  logic [XW-1:0]              wx, hx, emax, emin;
  logic [PW-1:0]              area;

  always_comb begin
    wx   = XW'(in_w);
    hx   = XW'(in_h);
    emax = (wx > hx) ? wx : hx;
    emin = (wx < hx) ? wx : hx;
    area = PW'(in_w) * PW'(in_h);
    kind_nxt[0] = KIND_PASS;
    kind_nxt[1] = KIND_PASS;
    mul_nxt  = '0;
    den_nxt  = '0;
    pass_nxt[0] = wx;
    pass_nxt[1] = hx;
    unique case (mode)
      MODE_LONG: begin
        if (long_lim != '0 && emax > XW'(long_lim)) begin
          kind_nxt[0] = KIND_DIV;
          kind_nxt[1] = KIND_DIV;
          mul_nxt  = {MUL_W'(long_lim), MUL_W'(long_lim)};
          den_nxt  = {emax, emax};
        end
      end
      MODE_SHORT: begin
        if (short_lim != '0 && emin > XW'(short_lim)) begin
          kind_nxt[0] = KIND_DIV;
          kind_nxt[1] = KIND_DIV;
          mul_nxt  = {MUL_W'(short_lim), MUL_W'(short_lim)};
          den_nxt  = {emin, emin};
        end
      end
      MODE_WIDTH: begin
        if (width_tgt != '0 && !(wx <= XW'(width_tgt) && keep)) begin
          pass_nxt[0] = XW'(width_tgt);
          if (keep) begin
            kind_nxt[1] = KIND_DIV;
            mul_nxt[1]  = MUL_W'(width_tgt);
            den_nxt[1]  = wx;
          end
        end
      end
      MODE_HEIGHT: begin
        if (height_tgt != '0 && !(hx <= XW'(height_tgt) && keep)) begin
          pass_nxt[1] = XW'(height_tgt);
          if (keep) begin
            kind_nxt[0] = KIND_DIV;
            mul_nxt[0]  = MUL_W'(height_tgt);
            den_nxt[0]  = hx;
          end
        end
      end
      MODE_PCT: begin
        if (pct != '0 && 32'(pct) < PCT_FULL) begin
          kind_nxt[0] = KIND_DIV;
          kind_nxt[1] = KIND_DIV;
          mul_nxt  = {MUL_W'(pct), MUL_W'(pct)};
          den_nxt  = {XW'(PCT_FULL), XW'(PCT_FULL)};
        end
      end
      MODE_MEGA: begin
        // Each side is the root of side * limit / other side; the source
        // side is also the cap of the result.
        if (pix != '0 && area > PW'(pix)) begin
          kind_nxt[0] = KIND_ROOT;
          kind_nxt[1] = KIND_ROOT;
          mul_nxt  = {pix, pix};
          den_nxt  = {wx, hx};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_inv_r  <= (in_w == '0) || (in_h == '0);
      s1_mega_r <= (kind_nxt[0] == KIND_ROOT);
      s1_kind_r <= kind_nxt;
      s1_dim_r  <= {in_h, in_w};
      s1_mul_r  <= mul_nxt;
      s1_den_r  <= den_nxt;
      s1_pass_r <= pass_nxt;
    end
  end

  // Stage 2: multiply.
  logic                  s2_vld_r, s2_inv_r, s2_mega_r;
  kind_t [1:0]           s2_kind_r;
  logic [1:0][PW-1:0]    s2_prod_r;
  logic [1:0][XW-1:0]    s2_den_r, s2_pass_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_inv_r  <= s1_inv_r;
      s2_mega_r <= s1_mega_r;
      s2_kind_r <= s1_kind_r;
      s2_den_r  <= s1_den_r;
      s2_pass_r <= s1_pass_r;
      for (int i = 0; i < 2; i++) begin
        s2_prod_r[i] <= PW'(s1_dim_r[i]) * PW'(s1_mul_r[i]);
      end
    end
  end

  // Stage 3: dividend and divisor. Rounding to nearest, ties upward, is
  // (2n + d) / 2d; the root path needs 4n / d for a half-step search.
  logic [1:0][AW-1:0] a_nxt;
  logic [1:0][BW-1:0] b_nxt;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (s2_mega_r) begin
        a_nxt[i] = {s2_prod_r[i], 2'b00};
        b_nxt[i] = BW'(s2_den_r[i]);
      end else begin
        a_nxt[i] = AW'({s2_prod_r[i], 1'b0}) + AW'(s2_den_r[i]);
        b_nxt[i] = {s2_den_r[i], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_inv  <= s2_inv_r;
      out_a    <= a_nxt;
      out_b    <= b_nxt;
      out_kind <= s2_kind_r;
      out_pass <= s2_pass_r;
    end
  end

endmodule

>>> sv/rdc_div.sv
// ----------------------------------------------------------------------------
// rdc_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rdc_div #(
  parameter int AW  = 50,
  parameter int BW  = 17,
  parameter int SBW = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_vld,
  input  logic [AW-1:0]  in_a,
  input  logic [BW-1:0]  in_b,
  input  logic [SBW-1:0] in_sb,
  output logic           out_vld,
  output logic [AW-1:0]  out_q,
  output logic [SBW-1:0] out_sb
);
  logic           vld_r [AW];
  logic [AW-1:0]  a_r   [AW];
  logic [AW-1:0]  q_r   [AW];
  logic [BW-1:0]  rem_r [AW];
  logic [BW-1:0]  b_r   [AW];
  logic [SBW-1:0] sb_r  [AW];

  for (genvar s = 0; s < AW; s++) begin : g_stage
    logic           vi;
    logic [AW-1:0]  ai, qi;
    logic [BW-1:0]  ri, bi;
    logic [SBW-1:0] sbi;
    logic [BW:0]    part;
    logic           ge;

    if (s == 0) begin : g_first
      assign vi  = in_vld;
      assign ai  = in_a;
      assign qi  = '0;
      assign ri  = '0;
      assign bi  = in_b;
      assign sbi = in_sb;
    end else begin : g_next
      assign vi  = vld_r[s-1];
      assign ai  = a_r[s-1];
      assign qi  = q_r[s-1];
      assign ri  = rem_r[s-1];
      assign bi  = b_r[s-1];
      assign sbi = sb_r[s-1];
    end

    assign part = {ri, ai[AW-1]};
    assign ge   = part >= {1'b0, bi};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv) begin
        vld_r[s] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        a_r[s]   <= ai << 1;
        q_r[s]   <= {qi[AW-2:0], ge};
        rem_r[s] <= ge ? BW'(part - {1'b0, bi}) : part[BW-1:0];
        b_r[s]   <= bi;
        sb_r[s]  <= sbi;
      end
    end
  end

  assign out_vld = vld_r[AW-1];
  assign out_q   = q_r[AW-1];
  assign out_sb  = sb_r[AW-1];

endmodule

>>> sv/rdc_sqrt.sv
// ----------------------------------------------------------------------------
// rdc_sqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module rdc_sqrt #(
  parameter int RW  = 17,
  parameter int SBW = 4,
  localparam int SW = 2 * RW
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_vld,
  input  logic [SW-1:0]  in_x,
  input  logic [SBW-1:0] in_sb,
  output logic           out_vld,
  output logic [RW-1:0]  out_root,
  output logic [SBW-1:0] out_sb
);
  logic           vld_r  [RW];
  logic [SW-1:0]  x_r    [RW];
  logic [RW:0]    rem_r  [RW];
  logic [RW-1:0]  root_r [RW];
  logic [SBW-1:0] sb_r   [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic           vi;
    logic [SW-1:0]  xi;
    logic [RW:0]    ri;
    logic [RW-1:0]  oi;
    logic [SBW-1:0] sbi;
    logic [RW+2:0]  part, trial;
    logic           ge;

    if (s == 0) begin : g_first
      assign vi  = in_vld;
      assign xi  = in_x;
      assign ri  = '0;
      assign oi  = '0;
      assign sbi = in_sb;
    end else begin : g_next
      assign vi  = vld_r[s-1];
      assign xi  = x_r[s-1];
      assign ri  = rem_r[s-1];
      assign oi  = root_r[s-1];
      assign sbi = sb_r[s-1];
    end

    assign part  = {ri, xi[SW-1:SW-2]};
    assign trial = {1'b0, oi, 2'b01};
    assign ge    = part >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv) begin
        vld_r[s] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[s]    <= xi << 2;
        rem_r[s]  <= ge ? (RW+1)'(part - trial) : part[RW:0];
        root_r[s] <= {oi[RW-2:0], ge};
        sb_r[s]   <= sbi;
      end
    end
  end

  assign out_vld  = vld_r[RW-1];
  assign out_root = root_r[RW-1];
  assign out_sb   = sb_r[RW-1];

endmodule

>>> sv/resize_dimension_calc.sv
// ----------------------------------------------------------------------------
// resize_dimension_calc
// Export resize size calculator: source width and height in, resized size out.
// ----------------------------------------------------------------------------
// The block takes one source size per cycle when not stalled and returns one
// result per item, in order. The pipeline has DIM_BITS + 34 divider stages,
// DIM_BITS + 1 square root stages and four more (three set-up stages and the
// output register); every stage moves on together, so a stall on the output
// holds the whole pipeline and the sustained rate is one item per cycle while
// out_ready is high. Configuration registers are to be written through cfg_we
// only while no item is in flight; the block itself does not enforce it.
module resize_dimension_calc #(
  parameter int DIM_BITS = rdc_pkg::DIM_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [DIM_BITS-1:0]            in_src_width,
  input  logic [DIM_BITS-1:0]            in_src_height,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [DIM_BITS-1:0]            out_width,
  output logic [DIM_BITS-1:0]            out_height,
  input  logic                           cfg_we,
  input  logic [rdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rdc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rdc_pkg::*;

  localparam int XW  = (DIM_BITS > 16) ? DIM_BITS : 16;
  localparam int PW  = DIM_BITS + MUL_W;
  localparam int AW  = PW + 2;
  localparam int BW  = XW + 1;
  localparam int RW  = DIM_BITS + 1;
  localparam int SW  = 2 * RW;
  localparam int DSB = 1 + 2 + XW;
  localparam int QSB = 1 + 2 + DIM_BITS;

  // Configuration registers.
  mode_t                mode_r;
  logic [LIMIT_W-1:0]   long_r, short_r, wt_r, ht_r;
  logic                 keep_r;
  logic [PCT_W-1:0]     pct_r;
  logic [MUL_W-1:0]     pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_LONG;
      long_r  <= '0;
      short_r <= '0;
      wt_r    <= '0;
      ht_r    <= '0;
      keep_r  <= 1'b1;
      pct_r   <= '0;
      pix_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE:   mode_r  <= mode_t'(cfg_wdata[2:0]);
        CFG_LONG:   long_r  <= cfg_wdata[LIMIT_W-1:0];
        CFG_SHORT:  short_r <= cfg_wdata[LIMIT_W-1:0];
        CFG_WIDTH:  wt_r    <= cfg_wdata[LIMIT_W-1:0];
        CFG_HEIGHT: ht_r    <= cfg_wdata[LIMIT_W-1:0];
        CFG_KEEP:   keep_r  <= cfg_wdata[0];
        CFG_PCT:    pct_r   <= cfg_wdata[PCT_W-1:0];
        CFG_PIX:    pix_r   <= cfg_wdata[MUL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic adv;
  logic out_valid_r;
  logic [DIM_BITS-1:0] out_width_r, out_height_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Front end.
  logic                f_vld, f_inv;
  logic [1:0][AW-1:0]  f_a;
  logic [1:0][BW-1:0]  f_b;
  kind_t [1:0]         f_kind;
  logic [1:0][XW-1:0]  f_pass;

  rdc_front #(.DIM_BITS(DIM_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_vld     (in_valid),
    .in_w       (in_src_width),
    .in_h       (in_src_height),
    .mode       (mode_r),
    .long_lim   (long_r),
    .short_lim  (short_r),
    .width_tgt  (wt_r),
    .height_tgt (ht_r),
    .keep       (keep_r),
    .pct        (pct_r),
    .pix        (pix_r),
    .out_vld    (f_vld),
    .out_inv    (f_inv),
    .out_a      (f_a),
    .out_b      (f_b),
    .out_kind   (f_kind),
    .out_pass   (f_pass)
  );

  logic [1:0]          d_vld, q_vld;
  logic [1:0][AW-1:0]  d_q;
  logic [1:0][DSB-1:0] d_sb;
  logic [1:0][QSB-1:0] q_in_sb, q_sb;
  logic [1:0][RW-1:0]  q_root;
  logic [1:0][DIM_BITS-1:0] res;

  for (genvar i = 0; i < 2; i++) begin : g_axis
    logic [AW-1:0]       pass_ext, sel;
    logic [DIM_BITS-1:0] val;
    kind_t               dkind, qkind;
    logic                qinv;
    logic [DIM_BITS-1:0] qval;
    logic [RW-1:0]       half;
    logic [RW-1:0]       pick;
    logic [DIM_BITS-1:0] sat;

    rdc_div #(.AW(AW), .BW(BW), .SBW(DSB)) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .in_vld  (f_vld),
      .in_a    (f_a[i]),
      .in_b    (f_b[i]),
      .in_sb   ({f_inv, f_kind[i], f_pass[i]}),
      .out_vld (d_vld[i]),
      .out_q   (d_q[i]),
      .out_sb  (d_sb[i])
    );

    // Saturate the quotient or the carried value to the output width.
    assign dkind    = kind_t'(d_sb[i][XW+1:XW]);
    assign pass_ext = AW'(d_sb[i][XW-1:0]);
    assign sel      = (dkind == KIND_DIV) ? d_q[i] : pass_ext;
    assign val      = (|sel[AW-1:DIM_BITS]) ? '1 : sel[DIM_BITS-1:0];
    assign q_in_sb[i] = {d_sb[i][DSB-1], dkind, val};

    rdc_sqrt #(.RW(RW), .SBW(QSB)) u_sqrt (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_vld   (d_vld[i]),
      .in_x     (d_q[i][SW-1:0]),
      .in_sb    (q_in_sb[i]),
      .out_vld  (q_vld[i]),
      .out_root (q_root[i]),
      .out_sb   (q_sb[i])
    );

    // The root is of four times the ratio, so halving (root + 1) rounds the
    // true root to nearest; the source side caps it.
    assign qinv  = q_sb[i][QSB-1];
    assign qkind = kind_t'(q_sb[i][DIM_BITS+1:DIM_BITS]);
    assign qval  = q_sb[i][DIM_BITS-1:0];
    assign half  = RW'(((RW+1)'(q_root[i]) + (RW+1)'(1)) >> 1);
    assign pick  = (qkind == KIND_ROOT && half < RW'(qval)) ? half : RW'(qval);
    assign sat   = pick[DIM_BITS-1:0];
    assign res[i] = qinv ? '0 : ((sat == '0) ? DIM_BITS'(1) : sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= q_vld[0] && q_vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_width_r  <= res[0];
      out_height_r <= res[1];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_width  = out_width_r;
  assign out_height = out_height_r;

endmodule

>>> tb/resize_dimension_calc_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resize_dimension_calc_tb
// Self-checking bench for the export resize size calculator.
// ----------------------------------------------------------------------------
// A directed table covers every resize mode, the disabled and already-met
// limits, invalid sources, clamping and the register extremes. Random phases
// follow, each with fresh register values and some with idling or stalling sides.
// Every result is checked against its table row or a local resize model.
module resize_dimension_calc_tb;
  import rdc_pkg::*;

  localparam int DW       = 16;
  localparam int SETTLE   = 80;
  localparam int MAX_CYC  = 400000;
  localparam int N_PHASES = 16;
  localparam int PER_PH   = 94;

  typedef struct packed {
    logic [31:0] mode;
    logic [31:0] lim_long;
    logic [31:0] lim_short;
    logic [31:0] tgt_w;
    logic [31:0] tgt_h;
    logic [31:0] keep;
    logic [31:0] pct;
    logic [31:0] pix;
  } regs_t;

  typedef struct packed {
    logic [DW-1:0] w;
    logic [DW-1:0] h;
  } dims_t;

  typedef struct packed {
    logic [3:0]    set;
    logic [DW-1:0] w;
    logic [DW-1:0] h;
    logic          typed;
    logic [DW-1:0] ew;
    logic [DW-1:0] eh;
  } row_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [DW-1:0] in_src_width = '0;
  logic [DW-1:0] in_src_height = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [DW-1:0] out_width;
  logic [DW-1:0] out_height;
  logic          cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  regs_t  cur;
  dims_t  sizes_due[$];
  int     errors = 0;
  int     cycles = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;

  resize_dimension_calc u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_src_width(in_src_width), .in_src_height(in_src_height),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_width(out_width), .out_height(out_height),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic longint unsigned round_div(longint unsigned num,
                                                longint unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  // Nearest integer to sqrt(a/b), ties upward, found by bisection on 0..cap.
  function automatic longint unsigned round_root(longint unsigned a,
                                                 longint unsigned b,
                                                 longint unsigned cap);
    longint unsigned lim, lo, hi, mid, t;
    lim = (4 * a) / b;
    lo = 0;
    hi = cap;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      t = 2 * mid - 1;
      if (t * t <= lim) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic dims_t resized_dims(regs_t r, logic [DW-1:0] sw,
                                         logic [DW-1:0] sh);
    longint unsigned w, h, ow, oh, e, lim, pct, pix, dmax;
    logic [2:0] mode;
    logic keep;
    dims_t d;
    w = 64'(sw); h = 64'(sh); ow = w; oh = h;
    dmax = (64'd1 << DW) - 1;
    mode = r.mode[2:0];
    keep = r.keep[0];
    pct = 64'(r.pct[14:0]);
    pix = 64'(r.pix);
    if (w == 0 || h == 0) return '0;
    case (mode)
      MODE_LONG: begin
        lim = 64'(r.lim_long[15:0]);
        e = (w > h) ? w : h;
        if (lim != 0 && e > lim) begin
          ow = round_div(w * lim, e);
          oh = round_div(h * lim, e);
        end
      end
      MODE_SHORT: begin
        lim = 64'(r.lim_short[15:0]);
        e = (w < h) ? w : h;
        if (lim != 0 && e > lim) begin
          ow = round_div(w * lim, e);
          oh = round_div(h * lim, e);
        end
      end
      MODE_WIDTH: begin
        lim = 64'(r.tgt_w[15:0]);
        if (lim != 0 && !(w <= lim && keep)) begin
          ow = lim;
          if (keep) oh = round_div(h * lim, w);
        end
      end
      MODE_HEIGHT: begin
        lim = 64'(r.tgt_h[15:0]);
        if (lim != 0 && !(h <= lim && keep)) begin
          oh = lim;
          if (keep) ow = round_div(w * lim, h);
        end
      end
      MODE_PCT: begin
        if (pct != 0 && pct < PCT_FULL) begin
          ow = round_div(w * pct, PCT_FULL);
          oh = round_div(h * pct, PCT_FULL);
        end
      end
      MODE_MEGA: begin
        if (pix != 0 && w * h > pix) begin
          ow = round_root(w * pix, h, w);
          oh = round_root(h * pix, w, h);
        end
      end
      default: ;
    endcase
    if (ow > dmax) ow = dmax;
    if (oh > dmax) oh = dmax;
    if (ow < 1) ow = 1;
    if (oh < 1) oh = 1;
    d.w = ow[DW-1:0];
    d.h = oh[DW-1:0];
    return d;
  endfunction

  always @(posedge clk) begin
    dims_t exp_d;
    if (rst_n && out_valid && out_ready) begin
      if (sizes_due.size() == 0) begin
        $display("%0t: unexpected result %0d x %0d", $time, out_width, out_height);
        errors++;
      end else begin
        exp_d = sizes_due.pop_front();
        if (out_width !== exp_d.w) begin
          $display("%0t: out_width expected %0d actual %0d", $time, exp_d.w, out_width);
          errors++;
        end
        if (out_height !== exp_d.h) begin
          $display("%0t: out_height expected %0d actual %0d", $time, exp_d.h,
                   out_height);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (sizes_due.size() != 0) @(posedge clk);
  endtask

  // Registers change only with nothing in flight.
  task automatic load_regs(regs_t r);
    logic [31:0] vals [8];
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    vals = '{r.mode, r.lim_long, r.lim_short, r.tgt_w, r.tgt_h, r.keep, r.pct, r.pix};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur = r;
  endtask

  // Drives one beat; in_valid is left high so that back-to-back beats follow.
  task automatic send_size(logic [DW-1:0] w, logic [DW-1:0] h, logic typed,
                           dims_t typed_d);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_src_width <= w;
    in_src_height <= h;
    do @(posedge clk); while (!in_ready);
    sizes_due.insert(sizes_due.size(), typed ? typed_d : resized_dims(cur, w, h));
  endtask

  function automatic logic [31:0] pick_dim_reg();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF;
      3: return $urandom;
      default: return $urandom_range(1, 4000);
    endcase
  endfunction

  function automatic logic [DW-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3, 4, 5, 6: return DW'($urandom);
      default: return DW'($urandom_range(1, 5000));
    endcase
  endfunction

  regs_t regs_sets [9];
  row_t  rows [$];

  initial begin
    regs_t r;
    dims_t td;
    regs_sets[0] = '{MODE_LONG, 0, 0, 0, 0, 1, 0, 0};
    regs_sets[1] = '{MODE_LONG, 100, 0, 0, 0, 1, 0, 0};
    regs_sets[2] = '{MODE_SHORT, 0, 100, 0, 0, 1, 0, 0};
    regs_sets[3] = '{MODE_WIDTH, 0, 0, 50, 0, 1, 0, 0};
    regs_sets[4] = '{MODE_WIDTH, 0, 0, 200, 0, 0, 0, 0};
    regs_sets[5] = '{MODE_HEIGHT, 0, 0, 0, 10, 1, 0, 0};
    regs_sets[6] = '{MODE_PCT, 0, 0, 0, 0, 1, 128, 0};
    regs_sets[7] = '{MODE_MEGA, 0, 0, 0, 0, 1, 0, 100};
    regs_sets[8] = '{32'd6, 9, 9, 9, 9, 0, 25600, 1};
    rows = '{
      '{0, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF},
      '{0, 0, 5, 1, 0, 0},
      '{0, 5, 0, 1, 0, 0},
      '{1, 400, 200, 1, 100, 50},
      '{1, 1, 16'hFFFF, 1, 1, 100},
      '{1, 80, 60, 1, 80, 60},
      '{2, 16'hFFFF, 200, 1, 32768, 100},
      '{2, 16'hFFFF, 16'hFFFE, 0, 0, 0},
      '{3, 100, 30, 1, 50, 15},
      '{3, 40, 30, 1, 40, 30},
      '{3, 16'hFFFF, 1, 0, 0, 0},
      '{4, 40, 30, 1, 200, 30},
      '{4, 16'hFFFF, 16'hFFFF, 1, 200, 16'hFFFF},
      '{5, 30, 20, 1, 15, 10},
      '{5, 16'hFFFF, 7, 0, 0, 0},
      '{6, 200, 400, 1, 1, 2},
      '{6, 16'hFFFF, 16'hFFFF, 0, 0, 0},
      '{7, 100, 100, 1, 10, 10},
      '{7, 16'hFFFF, 3, 0, 0, 0},
      '{7, 9, 10, 1, 9, 10},
      '{8, 1234, 4321, 1, 1234, 4321},
      '{8, 0, 16'hFFFF, 1, 0, 0}
    };
    cur = regs_sets[0];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (i == 0 || rows[i].set != rows[i-1].set) begin
        in_valid <= 1'b0;
        load_regs(regs_sets[rows[i].set]);
      end
      td.w = rows[i].ew;
      td.h = rows[i].eh;
      send_size(rows[i].w, rows[i].h, rows[i].typed, td);
    end
    // The other extremes of the percentage register, then mode 7.
    r = regs_sets[6];
    r.pct = 25599;
    in_valid <= 1'b0;
    load_regs(r);
    send_size(16'hFFFF, 16'd1, 1'b0, '0);
    r.mode = 32'd7;
    r.pct = 32'h7FFF;
    r.pix = 32'hFFFFFFFF;
    in_valid <= 1'b0;
    load_regs(r);
    send_size(16'd77, 16'd88, 1'b1, '{16'd77, 16'd88});

    for (int p = 0; p < N_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      r.mode = (p < 8) ? p : $urandom_range(0, 7);
      r.lim_long = pick_dim_reg();
      r.lim_short = pick_dim_reg();
      r.tgt_w = pick_dim_reg();
      r.tgt_h = pick_dim_reg();
      r.keep = $urandom;
      case ($urandom_range(0, 4))
        0: r.pct = 0;
        1: r.pct = 32'h7FFF;
        2: r.pct = $urandom_range(1, 25599);
        default: r.pct = $urandom;
      endcase
      case ($urandom_range(0, 4))
        0: r.pix = 0;
        1: r.pix = 1;
        2: r.pix = 32'hFFFFFFFF;
        3: r.pix = $urandom;
        default: r.pix = $urandom_range(1, 2000000);
      endcase
      in_valid <= 1'b0;
      load_regs(r);
      for (int k = 0; k < PER_PH; k++) begin
        if (p == 5 && k == 40) begin
          // Hold off until the pipeline has emptied completely.
          in_valid <= 1'b0;
          wait_drained();
          @(posedge clk);
        end
        send_size(pick_dim(), pick_dim(), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> resize_dimension_calc.f
sv/rdc_pkg.sv
sv/rdc_front.sv
sv/rdc_div.sv
sv/rdc_sqrt.sv
sv/resize_dimension_calc.sv
tb/resize_dimension_calc_tb.sv
